### hdl/wavh_pkg.sv
// Package for the WAVE header checker: result codes, parse phases,
// header byte offsets, tag words and the result record.
// No dependencies.
package wavh_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RateW   = 31;
  localparam int unsigned SampleW = 16;
  localparam int unsigned TotalW  = 30;
  localparam int unsigned PosW    = 6;
  localparam int unsigned WordW   = 32;

  // Rate register value after reset.
  localparam logic [RateW-1:0] RateReset = RateW'(32000);

  // Offset added to each signed sample.
  localparam logic [SampleW-1:0] SampleOffset = 16'd32767;

  // Required fmt fields.
  localparam logic [WordW-1:0]   FmtSizePcm  = 32'd16;
  localparam logic [SampleW-1:0] FormatPcm   = 16'd1;
  localparam logic [SampleW-1:0] ChanMono    = 16'd1;
  localparam logic [SampleW-1:0] ChanStereo  = 16'd2;
  localparam logic [SampleW-1:0] BitsPcm16   = 16'd16;

  // Chunk tags as little-endian words.
  localparam logic [WordW-1:0] TagRiff = 32'h4646_4952;
  localparam logic [WordW-1:0] TagWave = 32'h4556_4157;
  localparam logic [WordW-1:0] TagFmt  = 32'h2074_6d66;
  localparam logic [WordW-1:0] TagData = 32'h6174_6164;

  // Offsets of the last byte of each header field that matters.
  localparam logic [PosW-1:0] PosRiff     = 6'd3;
  localparam logic [PosW-1:0] PosWave     = 6'd11;
  localparam logic [PosW-1:0] PosFmt      = 6'd15;
  localparam logic [PosW-1:0] PosFmtSize  = 6'd19;
  localparam logic [PosW-1:0] PosFormat   = 6'd21;
  localparam logic [PosW-1:0] PosChannels = 6'd23;
  localparam logic [PosW-1:0] PosRate     = 6'd27;
  localparam logic [PosW-1:0] PosBits     = 6'd35;
  localparam logic [PosW-1:0] PosData     = 6'd39;
  localparam logic [PosW-1:0] PosDataLen  = 6'd43;

  typedef enum logic [1:0] {
    KindAccept = 2'd0,
    KindSample = 2'd1,
    KindReject = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    RejNone     = 4'd0,
    RejRiff     = 4'd1,
    RejWave     = 4'd2,
    RejFmt      = 4'd3,
    RejFmtSize  = 4'd4,
    RejFormat   = 4'd5,
    RejChannels = 4'd6,
    RejData     = 4'd7,
    RejRate     = 4'd8,
    RejMono     = 4'd9,
    RejBits     = 4'd10
  } rej_e;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhHeader  = 2'd1,
    PhSamples = 2'd2,
    PhDone    = 2'd3
  } phase_e;

  // One result item.
  typedef struct packed {
    kind_e              kind;
    rej_e               code;
    logic [SampleW-1:0] sample;
    logic [TotalW-1:0]  total;
    logic               last;
  } result_t;

endpackage

### hdl/wavh_in_reg.sv
// Input register of the WAVE header checker: holds one accepted byte item.
// Depends on wavh_pkg.
module wavh_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [wavh_pkg::ByteW-1:0] file_byte_i,
  input  logic                       first_byte_i,
  input  logic                       take_i,
  output logic                       vld_o,
  output logic [wavh_pkg::ByteW-1:0] byte_o,
  output logic                       first_o
);
  import wavh_pkg::*;

  logic             vld_q, vld_d;
  logic [ByteW-1:0] byte_q;
  logic             first_q;
  logic             accept;

  // A full register stalls unless its item moves on in this cycle.
  assign in_stall_o = vld_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= file_byte_i;
      first_q <= first_byte_i;
    end
  end

  assign vld_o   = vld_q;
  assign byte_o  = byte_q;
  assign first_o = first_q;

endmodule

### hdl/wavh_parse.sv
// Header parser and sample converter of the WAVE header checker.
// Holds all parse state and forms at most one result per byte item.
// Depends on wavh_pkg.
module wavh_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [wavh_pkg::ByteW-1:0] byte_i,
  input  logic                       first_i,
  input  logic [wavh_pkg::RateW-1:0] req_rate_i,
  output logic                       res_vld_o,
  output wavh_pkg::result_t          res_o
);
  import wavh_pkg::*;

  phase_e             phase_q, phase_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [WordW-1:0]   shift_q, shift_d;
  logic               mono_q, mono_d;
  logic               bits_ok_q, bits_ok_d;
  logic [WordW-1:0]   rate_q, rate_d;
  logic [TotalW-1:0]  left_q, left_d;
  logic               low_pend_q, low_pend_d;
  logic [ByteW-1:0]   low_byte_q, low_byte_d;
  logic [SampleW-1:0] half;
  logic [TotalW-1:0]  total;
  logic               res_vld;
  result_t            res;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    shift_d    = shift_q;
    mono_d     = mono_q;
    bits_ok_d  = bits_ok_q;
    rate_d     = rate_q;
    left_d     = left_q;
    low_pend_d = low_pend_q;
    low_byte_d = low_byte_q;
    half       = '0;
    total      = '0;
    res_vld    = 1'b0;
    res        = '{kind: KindAccept, code: RejNone, sample: '0, total: '0, last: 1'b0};

    if (step_i) begin
      // A first byte restarts the parse whatever the phase.
      if (first_i) begin
        phase_d    = PhHeader;
        pos_d      = '0;
        shift_d    = '0;
        mono_d     = 1'b0;
        bits_ok_d  = 1'b0;
        rate_d     = '0;
        left_d     = '0;
        low_pend_d = 1'b0;
      end

      unique case (phase_d)
        PhHeader: begin
          shift_d = {byte_i, shift_d[WordW-1:ByteW]};
          half    = shift_d[WordW-1:WordW-SampleW];
          pos_d   = pos_d + 1'b1;
          res.kind = KindReject;
          res.last = 1'b1;
          unique case (first_i ? '0 : pos_q)
            PosRiff: begin
              if (shift_d != TagRiff) begin
                res_vld = 1'b1; res.code = RejRiff;
              end
            end
            PosWave: begin
              if (shift_d != TagWave) begin
                res_vld = 1'b1; res.code = RejWave;
              end
            end
            PosFmt: begin
              if (shift_d != TagFmt) begin
                res_vld = 1'b1; res.code = RejFmt;
              end
            end
            PosFmtSize: begin
              if (shift_d != FmtSizePcm) begin
                res_vld = 1'b1; res.code = RejFmtSize;
              end
            end
            PosFormat: begin
              if (half != FormatPcm) begin
                res_vld = 1'b1; res.code = RejFormat;
              end
            end
            PosChannels: begin
              if (half != ChanMono && half != ChanStereo) begin
                res_vld = 1'b1; res.code = RejChannels;
              end
              mono_d = (half == ChanMono);
            end
            PosRate: begin
              rate_d = shift_d;
            end
            PosBits: begin
              bits_ok_d = (half == BitsPcm16);
            end
            PosData: begin
              if (shift_d != TagData) begin
                res_vld = 1'b1; res.code = RejData;
              end
            end
            PosDataLen: begin
              // Final checks in order rate, mono, bits; then the sample count.
              res_vld = 1'b1;
              if (rate_q != {1'b0, req_rate_i}) begin
                res.code = RejRate;
              end else if (!mono_q) begin
                res.code = RejMono;
              end else if (!bits_ok_q) begin
                res.code = RejBits;
              end else begin
                total      = shift_d[WordW-1] ? '0 : {shift_d[WordW-2:4], 3'b000};
                left_d     = total;
                low_pend_d = 1'b0;
                phase_d    = (total == '0) ? PhDone : PhSamples;
                res.kind   = KindAccept;
                res.code   = RejNone;
                res.total  = total;
                res.last   = (total == '0);
              end
            end
            default: begin
            end
          endcase
          if (res_vld && res.kind == KindReject) begin
            phase_d = PhDone;
          end
        end
        PhSamples: begin
          // Pair bytes low first, then offset the signed sample.
          if (!low_pend_d) begin
            low_pend_d = 1'b1;
            low_byte_d = byte_i;
          end else begin
            low_pend_d = 1'b0;
            left_d     = left_d - 1'b1;
            res_vld    = 1'b1;
            res.kind   = KindSample;
            res.sample = {byte_i, low_byte_q} + SampleOffset;
            res.last   = (left_d == '0);
            if (left_d == '0) begin
              phase_d = PhDone;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      pos_q      <= '0;
      shift_q    <= '0;
      mono_q     <= 1'b0;
      bits_ok_q  <= 1'b0;
      rate_q     <= '0;
      left_q     <= '0;
      low_pend_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      shift_q    <= shift_d;
      mono_q     <= mono_d;
      bits_ok_q  <= bits_ok_d;
      rate_q     <= rate_d;
      left_q     <= left_d;
      low_pend_q <= low_pend_d;
    end
  end

  // The pending low byte is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    low_byte_q <= low_byte_d;
  end

  assign res_vld_o = res_vld;
  assign res_o     = res;

endmodule

### hdl/wavh_out_reg.sv
// Result register of the WAVE header checker: holds one result item.
// Depends on wavh_pkg.
module wavh_out_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  wavh_pkg::result_t            res_i,
  output logic                         ready_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [3:0]                   reject_code_o,
  output logic [wavh_pkg::SampleW-1:0] sample_out_o,
  output logic [wavh_pkg::TotalW-1:0]  sample_total_o,
  output logic                         last_o
);
  import wavh_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  // Free when empty or when the held item leaves in this cycle.
  assign ready_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o    = vld_q;
  assign kind_o         = res_q.kind;
  assign reject_code_o  = res_q.code;
  assign sample_out_o   = res_q.sample;
  assign sample_total_o = res_q.total;
  assign last_o         = res_q.last;

endmodule

### hdl/wav_header_check_pcm_offset.sv
// Top level of the WAVE header checker and PCM sample offset converter.
// Depends on wavh_pkg, wavh_in_reg, wavh_parse and wavh_out_reg.
//
//   Channel   Handshake                  Payload
//   input     in_valid_i / in_stall_o    file_byte_i, first_byte_i
//   output    out_valid_o / out_stall_i  kind_o, reject_code_o, sample_out_o,
//                                        sample_total_o, last_o
//   config    cfg_we_i                   cfg_data_i (required sample rate)
//
// One byte item is taken every cycle while the input is not stalled. A byte waits
// in the input register; its result, if any, passes through the combinational
// parse logic between the input and result registers into the result register.
// After reset the block waits for a byte marked first and the rate is 32000.
// An output stall holds the result register and, once the input register is
// full, stalls the input.
module wav_header_check_pcm_offset (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wavh_pkg::RateW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [wavh_pkg::ByteW-1:0]   file_byte_i,
  input  logic                         first_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [3:0]                   reject_code_o,
  output logic [wavh_pkg::SampleW-1:0] sample_out_o,
  output logic [wavh_pkg::TotalW-1:0]  sample_total_o,
  output logic                         last_o
);
  import wavh_pkg::*;

  logic [RateW-1:0] rate_q;
  logic             in_vld;
  logic [ByteW-1:0] in_byte;
  logic             in_first;
  logic             out_ready;
  logic             step;
  logic             res_vld;
  result_t          res;

  // Required rate register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
    end else if (cfg_we_i) begin
      rate_q <= cfg_data_i;
    end
  end

  // An item moves into the parser when the result register can take its result.
  assign step = in_vld && out_ready;

  wavh_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .file_byte_i  (file_byte_i),
    .first_byte_i (first_byte_i),
    .take_i       (step),
    .vld_o        (in_vld),
    .byte_o       (in_byte),
    .first_o      (in_first)
  );

  wavh_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte),
    .first_i    (in_first),
    .req_rate_i (rate_q),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  wavh_out_reg u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (res_vld),
    .res_i          (res),
    .ready_o        (out_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .reject_code_o  (reject_code_o),
    .sample_out_o   (sample_out_o),
    .sample_total_o (sample_total_o),
    .last_o         (last_o)
  );

endmodule
